// File: design/cci_pkg.sv
// Shared widths, register codes and reset values for the carousel cup indexer.
// Used by the channel interfaces and every module of the block; depends on nothing.
`default_nettype none

package cci_pkg;

   localparam int ENC_W      = 32;  // encoder count and rounded target
   localparam int RND_W      = 33;  // unsaturated rounded target
   localparam int CUP_W      = 4;
   localparam int POWER_W    = 8;
   localparam int TPC_W      = 16;
   localparam int FAR_W      = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICKS_PER_CUP = 2'd0,
      CSR_FORWARD_POWER = 2'd1,
      CSR_REVERSE_POWER = 2'd2,
      CSR_FAR_THRESHOLD = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_SAMPLE  = 1'b0,
      MODE_COMMAND = 1'b1
   } mode_type;

   localparam logic [TPC_W-1:0]          TPC_RESET     = 16'd1708;  // 6.67 in Q8.8
   localparam logic signed [POWER_W-1:0] FWD_PWR_RESET = 8'sd3;
   localparam logic signed [POWER_W-1:0] REV_PWR_RESET = -8'sd5;
   localparam logic [FAR_W-1:0]          FAR_RESET     = 6'd5;

endpackage

`default_nettype wire

// File: design/cci_if.sv
// Valid/ready channel interfaces of the carousel cup indexer: request, response, csr write.
// Depends on cci_pkg for field widths and the register index type.
`default_nettype none

interface cci_req_if;
   logic                              valid;
   logic                              ready;
   cci_pkg::mode_type                 mode;
   logic signed [cci_pkg::ENC_W-1:0]  encoder_count;
   logic [cci_pkg::CUP_W-1:0]         target_cup;

   modport source (output valid, mode, encoder_count, target_cup, input ready);
   modport sink   (input valid, mode, encoder_count, target_cup, output ready);
endinterface

interface cci_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [cci_pkg::POWER_W-1:0] motor_power;
   logic                               is_moving;
   logic [cci_pkg::CUP_W-1:0]          current_cup;
   logic signed [cci_pkg::ENC_W-1:0]   target_ticks;

   modport source (output valid, motor_power, is_moving, current_cup, target_ticks,
                   input ready);
   modport sink   (input valid, motor_power, is_moving, current_cup, target_ticks,
                   output ready);
endinterface

interface cci_csr_if;
   logic                              valid;
   logic                              ready;
   cci_pkg::csr_index_type            index;
   logic [cci_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/cci_round.sv
// Rounds a signed fixed-point position to whole encoder ticks, half away from zero.
// Depends on cci_pkg for the rounded width.
`default_nettype none

module cci_round #(
   parameter int FRACTION_BITS = 8
) (
   input  wire logic [32+FRACTION_BITS-1:0]      pos,
   output logic signed [cci_pkg::RND_W-1:0]      rounded
);

   localparam int POS_W = 32 + FRACTION_BITS;
   localparam logic [POS_W:0] HALF = (POS_W+1)'(1) << (FRACTION_BITS - 1);

   logic [POS_W:0] sum;

   // Negative values take half minus one, which turns the floor into round away from zero.
   always_comb begin
      sum     = {pos[POS_W-1], pos} + HALF - {{POS_W{1'b0}}, pos[POS_W-1]};
      rounded = sum[POS_W:FRACTION_BITS];
   end

endmodule

`default_nettype wire

// File: design/carousel_cup_indexer.sv
// Top level of the carousel cup indexer: csr bank, input register, position update.
// Depends on cci_pkg, the channel interfaces in cci_if.sv and cci_round.
//
// Usage:
//   req_ch carries one encoder sample per transaction, optionally with a cup command
//   (mode = command, target_cup). rsp_ch returns exactly one transaction per request:
//   motor power, moving flag, last reached cup and the rounded, saturated target.
//   csr_ch writes ticks_per_cup_q8 (0), forward_power (1), reverse_power (2) and
//   far_threshold (3); it is always ready and should be used only while idle.
// Timing:
//   A request lands in an input register; when rsp_ch is not stalled the carousel state
//   is updated and the response register is loaded from the input register.
//   One transaction per cycle is sustained while rsp_ch is not stalled: the finish check,
//   the cup-count multiply and the target add all sit in that single stage.
// Reset:
//   Synchronous reset clears the state (not homed, stopped, cup 0, target 0) and
//   reloads the csr defaults. The first command homes cup 0 to the encoder.
// Backpressure:
//   While rsp_ch is stalled the response and input registers hold; req_ch stays
//   ready until the input register is occupied too.
`default_nettype none

module carousel_cup_indexer #(
   parameter int CUP_COUNT     = 12,
   parameter int FRACTION_BITS = 8
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cci_req_if.sink    req_ch,
   cci_rsp_if.source  rsp_ch,
   cci_csr_if.sink    csr_ch
);

   localparam int POS_W = 32 + FRACTION_BITS;
   localparam int CNT_W = $clog2(CUP_COUNT + 64);   // holds CUP_COUNT + 15 and far_threshold
   localparam int SW    = CNT_W + 1;
   localparam int DLT_W = CNT_W + cci_pkg::TPC_W;
   localparam logic [CNT_W-1:0]        CUPS_U = CNT_W'(CUP_COUNT);
   localparam logic signed [SW-1:0]    CUPS_S = SW'(CUP_COUNT);

   // csr bank
   logic [cci_pkg::TPC_W-1:0]           tpc_ff;
   logic signed [cci_pkg::POWER_W-1:0]  fwd_pwr_ff;
   logic signed [cci_pkg::POWER_W-1:0]  rev_pwr_ff;
   logic [cci_pkg::FAR_W-1:0]           far_ff;

   // input register
   logic                                s1_valid_ff;
   cci_pkg::mode_type                   s1_mode_ff;
   logic signed [cci_pkg::ENC_W-1:0]    s1_enc_ff;
   logic [cci_pkg::CUP_W-1:0]           s1_cup_ff;

   // carousel state
   logic [POS_W-1:0]                    ref_ff, ref_in;
   logic [POS_W-1:0]                    target_ff, target_in;
   logic [cci_pkg::CUP_W-1:0]           reached_ff, reached_in;
   logic [cci_pkg::CUP_W-1:0]           goal_ff, goal_in;
   logic                                homed_ff, homed_in;
   logic                                motion_ff, motion_in;
   logic signed [cci_pkg::POWER_W-1:0]  drive_ff, drive_in;

   // response register
   logic                                rsp_valid_ff;
   logic signed [cci_pkg::POWER_W-1:0]  rsp_power_ff, rsp_power_in;
   logic                                rsp_moving_ff;
   logic [cci_pkg::CUP_W-1:0]           rsp_cup_ff;
   logic signed [cci_pkg::ENC_W-1:0]    rsp_ticks_ff, rsp_ticks_in;

   logic                                advance;
   logic                                step;
   logic signed [cci_pkg::RND_W-1:0]    rt_chk;
   logic signed [cci_pkg::RND_W-1:0]    rt_out;
   logic signed [cci_pkg::RND_W-1:0]    enc_ext;
   logic                                finish;
   logic                                cmd;
   logic signed [SW-1:0]                d;
   logic signed [SW-1:0]                far_s;
   logic signed [SW-1:0]                n_s;
   logic [DLT_W-1:0]                    delta;
   logic                                add_dir;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign step         = s1_valid_ff && advance;
   assign req_ch.ready = !s1_valid_ff || advance;
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpc_ff     <= cci_pkg::TPC_RESET;
         fwd_pwr_ff <= cci_pkg::FWD_PWR_RESET;
         rev_pwr_ff <= cci_pkg::REV_PWR_RESET;
         far_ff     <= cci_pkg::FAR_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            cci_pkg::CSR_TICKS_PER_CUP: tpc_ff     <= csr_ch.data;
            cci_pkg::CSR_FORWARD_POWER: fwd_pwr_ff <= csr_ch.data[cci_pkg::POWER_W-1:0];
            cci_pkg::CSR_REVERSE_POWER: rev_pwr_ff <= csr_ch.data[cci_pkg::POWER_W-1:0];
            cci_pkg::CSR_FAR_THRESHOLD: far_ff     <= csr_ch.data[cci_pkg::FAR_W-1:0];
            default: ;
         endcase
      end
   end

   cci_round #(.FRACTION_BITS(FRACTION_BITS)) u_round_chk (
      .pos     (target_ff),
      .rounded (rt_chk)
   );

   cci_round #(.FRACTION_BITS(FRACTION_BITS)) u_round_out (
      .pos     (target_in),
      .rounded (rt_out)
   );

   always_comb begin
      enc_ext = cci_pkg::RND_W'(s1_enc_ff);

      // finish check of a running move
      finish = motion_ff && ((drive_ff == '0) ||
                             (drive_ff > 0 && enc_ext >= rt_chk) ||
                             (drive_ff < 0 && enc_ext <= rt_chk));

      motion_in  = motion_ff && !finish;
      drive_in   = finish ? '0 : drive_ff;
      reached_in = finish ? goal_ff : reached_ff;
      ref_in     = finish ? target_ff : ref_ff;
      target_in  = target_ff;
      goal_in    = goal_ff;
      homed_in   = homed_ff;

      cmd = (s1_mode_ff == cci_pkg::MODE_COMMAND) && !motion_in &&
            (CNT_W'(s1_cup_ff) < CUPS_U);

      // home cup 0 on the first command
      if (cmd && !homed_ff) begin
         reached_in = '0;
         ref_in     = {s1_enc_ff, {FRACTION_BITS{1'b0}}};
         homed_in   = 1'b1;
      end

      d     = signed'(SW'(s1_cup_ff)) - signed'(SW'(reached_in));
      far_s = signed'(SW'(far_ff));
      if (d > 0 && d > far_s) begin
         n_s     = CUPS_S - d;
         add_dir = 1'b0;
      end else if (d > 0) begin
         n_s     = d;
         add_dir = 1'b1;
      end else if (d < -far_s) begin
         n_s     = CUPS_S + d;
         add_dir = 1'b1;
      end else begin
         n_s     = -d;
         add_dir = 1'b0;
      end
      delta = n_s[CNT_W-1:0] * tpc_ff;

      if (cmd && (s1_cup_ff != reached_in)) begin
         drive_in  = add_dir ? fwd_pwr_ff : rev_pwr_ff;
         target_in = add_dir ? ref_in + POS_W'(delta) : ref_in - POS_W'(delta);
         goal_in   = s1_cup_ff;
         motion_in = 1'b1;
      end

      rsp_power_in = motion_in ? drive_in : '0;

      // saturate the rounded target to 32 bits
      if (rt_out[cci_pkg::RND_W-1] != rt_out[cci_pkg::RND_W-2]) begin
         rsp_ticks_in = rt_out[cci_pkg::RND_W-1] ? {1'b1, {(cci_pkg::ENC_W-1){1'b0}}}
                                                 : {1'b0, {(cci_pkg::ENC_W-1){1'b1}}};
      end else begin
         rsp_ticks_in = rt_out[cci_pkg::ENC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ref_ff       <= '0;
         target_ff    <= '0;
         reached_ff   <= '0;
         goal_ff      <= '0;
         homed_ff     <= 1'b0;
         motion_ff    <= 1'b0;
         drive_ff     <= '0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (step) begin
            ref_ff     <= ref_in;
            target_ff  <= target_in;
            reached_ff <= reached_in;
            goal_ff    <= goal_in;
            homed_ff   <= homed_in;
            motion_ff  <= motion_in;
            drive_ff   <= drive_in;
         end
      end
   end

   // payload registers: hold while stalled
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         s1_mode_ff <= req_ch.mode;
         s1_enc_ff  <= req_ch.encoder_count;
         s1_cup_ff  <= req_ch.target_cup;
      end
      if (step) begin
         rsp_power_ff  <= rsp_power_in;
         rsp_moving_ff <= motion_in;
         rsp_cup_ff    <= reached_in;
         rsp_ticks_ff  <= rsp_ticks_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.motor_power  = rsp_power_ff;
   assign rsp_ch.is_moving    = rsp_moving_ff;
   assign rsp_ch.current_cup  = rsp_cup_ff;
   assign rsp_ch.target_ticks = rsp_ticks_ff;

   a_stopped_no_power: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_moving_ff |-> rsp_power_ff == '0)
      else $error("stopped response carries motor power");

   a_idle_drive_zero: assert property (@(posedge clock) disable iff (reset)
      !motion_ff |-> drive_ff == '0)
      else $error("drive power left set while idle");

   a_motion_homed: assert property (@(posedge clock) disable iff (reset)
      motion_ff |-> homed_ff)
      else $error("move in progress before homing");

   a_cups_in_range: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(reached_ff) < CUPS_U) && (CNT_W'(goal_ff) < CUPS_U))
      else $error("cup index out of range");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(target_ff) && $stable(motion_ff) && $stable(reached_ff))
      else $error("carousel state changed without a transaction");

endmodule

`default_nettype wire
